// ----- src/vrc_pkg.sv -----
// Package for the volume ray first-hit caster: constants, register indexes, sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package vrc_pkg;
  localparam int SIDE      = 64;
  localparam int SLICES    = 16;
  localparam int MAX_STEPS = 256;

  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 20;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 24;
  localparam int POS_FLD_W = 6;
  localparam int SLICE_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam int SIDE_BITS  = $clog2(SIDE);
  localparam int SLICE_BITS = $clog2(SLICES);
  localparam int ADDR_W     = SLICE_BITS + 2 * SIDE_BITS;
  localparam int STORE_DEPTH = SLICES * SIDE * SIDE;
  localparam int SLC_CMP_W  = 11;

  localparam int DIFF_W = COORD_W + 2;
  localparam int MAG_W  = DIFF_W - 1 + FRAC_W;
  localparam int T_W    = MAG_W + 1;
  localparam int POS_W  = 64;
  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int MULJ_W = $clog2(STEP_W);
  localparam int DCNT_W = $clog2(MAG_W + 1);

  localparam logic signed [DIFF_W-1:0] SIDE_FX = DIFF_W'(SIDE * 65536);

  localparam logic [REG_IDX_W-1:0] REG_STEP_X    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_Y    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_X_RESET    = 20'd65536;
  localparam logic [STEP_W-1:0]  STEP_Y_RESET    = 20'd0;
  localparam logic [CHAN_W-1:0]  THRESHOLD_RESET = 8'd50;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_DIV0,
    ST_DIV1,
    ST_SPAN,
    ST_MUL,
    ST_MSETUP,
    ST_MARCH,
    ST_CUBE1,
    ST_CUBE2,
    ST_FINISH
  } state_t;
endpackage
`default_nettype wire

// ----- src/vrc_div.sv -----
// Serial restoring divider for slab parameters: (diff * 65536) / den, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module vrc_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [vrc_pkg::DIFF_W-1:0] diff,
  input  wire logic signed [vrc_pkg::STEP_W-1:0] den,
  output logic                                   done,
  output logic signed [vrc_pkg::T_W-1:0]         quo
);
  localparam int DW = vrc_pkg::DIFF_W;
  localparam int MW = vrc_pkg::MAG_W;
  localparam int SW = vrc_pkg::STEP_W;

  logic              active;
  logic [vrc_pkg::DCNT_W-1:0] cnt;
  logic [MW-1:0]     dvd;
  logic [MW-1:0]     q;
  logic [SW-1:0]     rem;
  logic [SW-1:0]     den_mag;
  logic              neg;

  logic [DW-1:0]     diff_mag;
  logic [SW:0]       shifted;
  logic              ge;

  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign shifted  = {rem, dvd[MW-1]};
  assign ge       = shifted >= {1'b0, den_mag};
  assign quo      = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active  <= 1'b1;
        cnt     <= '0;
        dvd     <= {diff_mag[DW-2:0], {vrc_pkg::FRAC_W{1'b0}}};
        q       <= '0;
        rem     <= '0;
        den_mag <= den[SW-1] ? SW'(-den) : SW'(den);
        neg     <= diff[DW-1] ^ den[SW-1];
      end else if (active) begin
        rem <= ge ? SW'(shifted - {1'b0, den_mag}) : shifted[SW-1:0];
        q   <= {q[MW-2:0], ge};
        dvd <= {dvd[MW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == vrc_pkg::DCNT_W'(MW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/volume_ray_first_hit_caster.sv -----
// Top level: voxel store, slab clipper, serial step multiplier, voxel march and color cube.
//
// channel   direction  handshake                 payload
// cmd       in         start & !busy             action, voxel_col, voxel_row, slice,
//                                                voxel_color, ray_start_x, ray_start_y
// config    in         cfg_write                 cfg_index, cfg_data
// result    out        done (one cycle)          red_out, green_out, blue_out, hit
//
// A voxel write leaves busy low. A cast runs the serial divider (two slab
// bounds per moving axis), clips the span, runs the serial step multiplier,
// then does one voxel read per sample (up to MAX_STEPS - 1), cubes the color
// of a hit and finishes. Reset is synchronous; the voxel store has no clearing
// pass. The receiver cannot stall: done lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module volume_ray_first_hit_caster (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  action,
  input  wire logic [vrc_pkg::POS_FLD_W-1:0]         voxel_col,
  input  wire logic [vrc_pkg::POS_FLD_W-1:0]         voxel_row,
  input  wire logic [vrc_pkg::SLICE_W-1:0]           slice,
  input  wire logic [vrc_pkg::COLOR_W-1:0]           voxel_color,
  input  wire logic signed [vrc_pkg::COORD_W-1:0]    ray_start_x,
  input  wire logic signed [vrc_pkg::COORD_W-1:0]    ray_start_y,
  input  wire logic                                  cfg_write,
  input  wire logic [vrc_pkg::REG_IDX_W-1:0]         cfg_index,
  input  wire logic [vrc_pkg::STEP_W-1:0]            cfg_data,
  output logic                                       done,
  output logic [vrc_pkg::CHAN_W-1:0]                 red_out,
  output logic [vrc_pkg::CHAN_W-1:0]                 green_out,
  output logic [vrc_pkg::CHAN_W-1:0]                 blue_out,
  output logic                                       hit
);
  localparam int DW = vrc_pkg::DIFF_W;
  localparam int TW = vrc_pkg::T_W;
  localparam int PW = vrc_pkg::POS_W;
  localparam int SW = vrc_pkg::STEP_W;
  localparam int CW = vrc_pkg::CNT_W;
  localparam int FW = vrc_pkg::FRAC_W;
  localparam int SB = vrc_pkg::SIDE_BITS;
  localparam int NW = TW + 1 - FW;

  vrc_pkg::state_t state, state_next;

  logic signed [SW-1:0] step_x, step_y;
  logic [vrc_pkg::CHAN_W-1:0] dark_threshold;

  logic [vrc_pkg::COLOR_W-1:0] mem [vrc_pkg::STORE_DEPTH];
  logic [vrc_pkg::COLOR_W-1:0] rdata;

  logic [vrc_pkg::SLICE_W-1:0]        slc;
  logic signed [vrc_pkg::COORD_W-1:0] sx, sy;
  logic                               axis;
  logic                               bounded;
  logic signed [TW-1:0]               lo, hi, t0_tmp;
  logic [CW-1:0]                      count, idx;
  logic signed [PW-1:0]               acc, mcand, ex, ey, pos_x, pos_y;
  logic [vrc_pkg::MULJ_W-1:0]         mul_j;
  logic                               pend;
  logic                               hit_r;
  logic [vrc_pkg::COLOR_W-1:0]        color_r;
  logic [15:0]                        sq_r, sq_g, sq_b;
  logic [vrc_pkg::CHAN_W-1:0]         cb_r, cb_g, cb_b;

  logic accept, cast, slice_ok;
  logic signed [vrc_pkg::COORD_W-1:0] s_a;
  logic signed [SW-1:0]               d_a;
  logic signed [DW-1:0]               s_ext, neg_s, side_m_s, num0, num1, div_diff;
  logic                               d_zero, s_in;
  logic                               div_start, div_done;
  logic signed [TW-1:0]               div_quo;
  logic signed [TW:0]                 span;
  logic [NW-1:0]                      n_fx;
  logic [CW-1:0]                      count_calc;
  logic signed [PW-1:0]               acc_next, e_calc;
  logic                               mul_last;
  logic                               issuing, in_x, in_y, rd_en, bright;
  logic [vrc_pkg::ADDR_W-1:0]         waddr, raddr;
  logic                               wr_ok;

  assign accept   = start & ~busy;
  assign cast     = accept & action;
  assign slice_ok = vrc_pkg::SLC_CMP_W'(slice) < vrc_pkg::SLC_CMP_W'(vrc_pkg::SLICES);

  assign s_a      = axis ? sy : sx;
  assign d_a      = axis ? step_y : step_x;
  assign s_ext    = DW'(s_a);
  assign neg_s    = -s_ext;
  assign side_m_s = vrc_pkg::SIDE_FX - s_ext;
  assign num0     = d_a[SW-1] ? side_m_s : neg_s;
  assign num1     = d_a[SW-1] ? neg_s : side_m_s;
  assign div_diff = (state == vrc_pkg::ST_AXIS) ? num0 : num1;
  assign d_zero   = d_a == '0;
  assign s_in     = ~s_ext[DW-1] && s_ext <= vrc_pkg::SIDE_FX;

  assign span = {hi[TW-1], hi} - {lo[TW-1], lo};

  assign n_fx = span[TW:FW];
  always_comb begin
    if (!bounded) count_calc = CW'(vrc_pkg::MAX_STEPS);
    else if (lo < hi) begin
      if (n_fx > NW'(vrc_pkg::MAX_STEPS)) count_calc = CW'(vrc_pkg::MAX_STEPS);
      else count_calc = n_fx[CW-1:0];
    end else count_calc = '0;
  end

  assign mul_last = mul_j == vrc_pkg::MULJ_W'(SW - 1);
  always_comb begin
    if (!d_a[mul_j]) acc_next = acc;
    else if (mul_last) acc_next = acc - mcand;
    else acc_next = acc + mcand;
  end
  assign e_calc = PW'(s_a) + (acc_next >>> FW);

  assign issuing = idx < count;
  assign in_x    = ~pos_x[PW-1] && pos_x < PW'(vrc_pkg::SIDE_FX);
  assign in_y    = ~pos_y[PW-1] && pos_y < PW'(vrc_pkg::SIDE_FX);
  assign rd_en   = (state == vrc_pkg::ST_MARCH) && issuing && in_x && in_y;
  assign raddr   = {slc[vrc_pkg::SLICE_BITS-1:0], pos_y[FW +: SB], pos_x[FW +: SB]};
  assign bright  = ~(rdata[23:16] < dark_threshold && rdata[15:8] < dark_threshold &&
                     rdata[7:0] < dark_threshold);

  assign waddr = {slice[vrc_pkg::SLICE_BITS-1:0], voxel_row[SB-1:0], voxel_col[SB-1:0]};
  assign wr_ok = accept && !action && slice_ok &&
                 vrc_pkg::SLC_CMP_W'(voxel_col) < vrc_pkg::SLC_CMP_W'(vrc_pkg::SIDE) &&
                 vrc_pkg::SLC_CMP_W'(voxel_row) < vrc_pkg::SLC_CMP_W'(vrc_pkg::SIDE);

  always_ff @(posedge clk) begin
    if (wr_ok) mem[waddr] <= voxel_color;
    else if (rd_en) rdata <= mem[raddr];
  end

  vrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .diff  (div_diff),
    .den   (d_a),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vrc_pkg::ST_IDLE:
        if (cast) state_next = slice_ok ? vrc_pkg::ST_AXIS : vrc_pkg::ST_FINISH;
      vrc_pkg::ST_AXIS: begin
        if (!d_zero) state_next = vrc_pkg::ST_DIV0;
        else if (!s_in) state_next = vrc_pkg::ST_FINISH;
        else if (axis) state_next = vrc_pkg::ST_SPAN;
      end
      vrc_pkg::ST_DIV0:
        if (div_done) state_next = vrc_pkg::ST_DIV1;
      vrc_pkg::ST_DIV1:
        if (div_done) state_next = axis ? vrc_pkg::ST_SPAN : vrc_pkg::ST_AXIS;
      vrc_pkg::ST_SPAN:
        state_next = (bounded && lo < hi) ? vrc_pkg::ST_MUL : vrc_pkg::ST_MSETUP;
      vrc_pkg::ST_MUL:
        if (mul_last && axis) state_next = vrc_pkg::ST_MSETUP;
      vrc_pkg::ST_MSETUP:
        state_next = vrc_pkg::ST_MARCH;
      vrc_pkg::ST_MARCH: begin
        if (pend && bright) state_next = vrc_pkg::ST_CUBE1;
        else if (!issuing && !pend) state_next = vrc_pkg::ST_FINISH;
      end
      vrc_pkg::ST_CUBE1:  state_next = vrc_pkg::ST_CUBE2;
      vrc_pkg::ST_CUBE2:  state_next = vrc_pkg::ST_FINISH;
      vrc_pkg::ST_FINISH: state_next = vrc_pkg::ST_IDLE;
      default:            state_next = vrc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = state != vrc_pkg::ST_IDLE;
    div_start = ((state == vrc_pkg::ST_AXIS) && !d_zero) ||
                ((state == vrc_pkg::ST_DIV0) && div_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vrc_pkg::ST_IDLE;
      step_x         <= vrc_pkg::STEP_X_RESET;
      step_y         <= vrc_pkg::STEP_Y_RESET;
      dark_threshold <= vrc_pkg::THRESHOLD_RESET;
      done           <= 1'b0;
      pend           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == vrc_pkg::ST_FINISH;
      if (cfg_write) begin
        case (cfg_index)
          vrc_pkg::REG_STEP_X:    step_x <= cfg_data;
          vrc_pkg::REG_STEP_Y:    step_y <= cfg_data;
          vrc_pkg::REG_THRESHOLD: dark_threshold <= cfg_data[vrc_pkg::CHAN_W-1:0];
          default: ;
        endcase
      end
      if (state == vrc_pkg::ST_MSETUP) pend <= 1'b0;
      else if (state == vrc_pkg::ST_MARCH) pend <= rd_en;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      vrc_pkg::ST_IDLE:
        if (cast) begin
          slc     <= slice;
          sx      <= ray_start_x;
          sy      <= ray_start_y;
          axis    <= 1'b0;
          bounded <= 1'b0;
          hit_r   <= 1'b0;
        end
      vrc_pkg::ST_AXIS:
        if (d_zero) axis <= 1'b1;
      vrc_pkg::ST_DIV0:
        if (div_done) t0_tmp <= div_quo;
      vrc_pkg::ST_DIV1:
        if (div_done) begin
          bounded <= 1'b1;
          axis    <= 1'b1;
          if (!bounded || t0_tmp > lo) lo <= t0_tmp;
          if (!bounded || div_quo < hi) hi <= div_quo;
        end
      vrc_pkg::ST_SPAN: begin
        count <= count_calc;
        axis  <= 1'b0;
        ex    <= PW'(sx);
        ey    <= PW'(sy);
        acc   <= '0;
        mcand <= PW'(lo);
        mul_j <= '0;
      end
      vrc_pkg::ST_MUL: begin
        if (mul_last) begin
          if (axis) ey <= e_calc;
          else ex <= e_calc;
          axis  <= 1'b1;
          acc   <= '0;
          mcand <= PW'(lo);
          mul_j <= '0;
        end else begin
          acc   <= acc_next;
          mcand <= mcand <<< 1;
          mul_j <= mul_j + 1'b1;
        end
      end
      vrc_pkg::ST_MSETUP: begin
        pos_x <= ex + PW'(step_x);
        pos_y <= ey + PW'(step_y);
        idx   <= CW'(1);
      end
      vrc_pkg::ST_MARCH: begin
        if (issuing) begin
          pos_x <= pos_x + PW'(step_x);
          pos_y <= pos_y + PW'(step_y);
          idx   <= idx + 1'b1;
        end
        if (pend && bright) color_r <= rdata;
      end
      vrc_pkg::ST_CUBE1: begin
        sq_r <= {8'd0, color_r[23:16]} * {8'd0, color_r[23:16]};
        sq_g <= {8'd0, color_r[15:8]} * {8'd0, color_r[15:8]};
        sq_b <= {8'd0, color_r[7:0]} * {8'd0, color_r[7:0]};
      end
      vrc_pkg::ST_CUBE2: begin
        cb_r  <= 8'(({8'd0, sq_r} * {16'd0, color_r[23:16]}) >> 16);
        cb_g  <= 8'(({8'd0, sq_g} * {16'd0, color_r[15:8]}) >> 16);
        cb_b  <= 8'(({8'd0, sq_b} * {16'd0, color_r[7:0]}) >> 16);
        hit_r <= 1'b1;
      end
      vrc_pkg::ST_FINISH: begin
        red_out   <= hit_r ? cb_r : '0;
        green_out <= hit_r ? cb_g : '0;
        blue_out  <= hit_r ? cb_b : '0;
        hit       <= hit_r;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
